@@ rtl/scc_pkg.sv @@
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the stick channel conditioner.
// ----------------------------------------------------------------------------
`default_nettype none

package scc_pkg;

	// Channel count and field widths
	localparam int NCH    = 4;
	localparam int SMP_W  = 12;
	localparam int MAP_W  = 13;
	localparam int BIAS_W = 11;
	localparam int OUT_W  = 11;
	localparam int CFG_W  = 8;
	localparam int HC_W   = 5;
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Channel order inside the lane array
	localparam int CH_THR   = 0;
	localparam int CH_YAW   = 1;
	localparam int CH_PITCH = 2;
	localparam int CH_ROLL  = 3;

	// Output range and targets
	localparam logic [OUT_W-1:0] OUT_MIN     = 11'd1000;
	localparam logic [OUT_W-1:0] OUT_MAX     = 11'd2000;
	localparam logic [OUT_W-1:0] OUT_CENTER  = 11'd1500;
	localparam logic [OUT_W-1:0] THR_TARGET  = 11'd1000;
	localparam logic [OUT_W-1:0] AXIS_TARGET = 11'd1500;
	localparam logic [HC_W-1:0]  HOLD_SCANS  = 5'd20;

	// Register map (word index)
	localparam logic [1:0] REG_THR_SNAP  = 2'd0;
	localparam logic [1:0] REG_AXIS_SNAP = 2'd1;
	localparam logic [1:0] REG_TRIM_STEP = 2'd2;

	localparam logic [CFG_W-1:0] THR_SNAP_RST  = 8'd30;
	localparam logic [CFG_W-1:0] AXIS_SNAP_RST = 8'd10;
	localparam logic [CFG_W-1:0] TRIM_STEP_RST = 8'd10;

	// Input transaction
	typedef struct packed {
		logic [SMP_W-1:0] adc_throttle;
		logic [SMP_W-1:0] adc_yaw;
		logic [SMP_W-1:0] adc_pitch;
		logic [SMP_W-1:0] adc_roll;
		logic             calib_key;
		logic             trim_up;
		logic             trim_down;
		logic             trim_left;
		logic             trim_right;
	} scc_in_t;

	// Output transaction
	typedef struct packed {
		logic [OUT_W-1:0] throttle_out;
		logic [OUT_W-1:0] yaw_out;
		logic [OUT_W-1:0] pitch_out;
		logic [OUT_W-1:0] roll_out;
		logic             calib_done;
	} scc_out_t;

	// Trim keys of one scan
	typedef struct packed {
		logic up;
		logic down;
		logic left;
		logic right;
	} scc_keys_t;

	// Two ordered bias steps for one lane
	typedef struct packed {
		logic en1;
		logic neg1;
		logic en2;
		logic neg2;
	} scc_trim_t;

	// Calibration role of one scan
	typedef struct packed {
		logic take;
		logic clear;
		logic cmpl;
	} scc_flags_t;

	// Calibration finish sequence steps
	typedef struct packed {
		logic a;
		logic b;
		logic c;
	} scc_cal_t;

	// Window read qualifiers for the prefetched old sample
	typedef struct packed {
		logic ok;
		logic fwd;
	} scc_rd_t;

	// Per-cycle lane controls
	typedef struct packed {
		logic acc;
		logic en2;
		logic en3;
		logic fire3;
		logic take;
		logic clear;
		logic cmpl;
		logic cal_a;
		logic cal_b;
		logic bias_we;
		logic use_cal;
	} scc_lane_ctl_t;

endpackage

`default_nettype wire

@@ rtl/scc_cdiv.sv @@
// ----------------------------------------------------------------------------
// scc_cdiv
// Two-stage signed divide by a constant, truncating toward zero.
// Reciprocal multiply in stage a, one compare-and-bump fix in stage b.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_cdiv #(
	parameter int DIVISOR = 8,
	parameter int WIDTH   = 16
) (
	input  wire logic                    clk,
	input  wire logic                    en_a,
	input  wire logic                    en_b,
	input  wire logic signed [WIDTH-1:0] x,
	output logic signed [WIDTH-1:0]      q
);

	localparam int SH = WIDTH;
	localparam int RW = SH + 1;
	localparam int PW = WIDTH + RW;
	localparam int DW = $clog2(DIVISOR + 1);
	localparam int CW = WIDTH + DW;
	localparam logic [RW-1:0] RECIP = RW'((64'd1 << SH) / DIVISOR);

	logic             neg_a;
	logic [WIDTH-1:0] mag_a;
	logic [PW-1:0]    prod_a;
	logic [WIDTH-1:0] mag;
	logic [WIDTH-1:0] q0;
	logic [CW-1:0]    qd;
	logic [CW-1:0]    rem;
	logic [WIDTH-1:0] qm;

	// Stage a: magnitude times reciprocal
	assign mag = x[WIDTH-1] ? WIDTH'(-x) : WIDTH'(x);

	always_ff @(posedge clk) begin
		if (en_a) begin
			neg_a  <= x[WIDTH-1];
			mag_a  <= mag;
			prod_a <= PW'(mag) * PW'(RECIP);
		end
	end

	// Stage b: estimate is low by at most one
	assign q0  = prod_a[SH +: WIDTH];
	assign qd  = CW'(q0) * CW'(DIVISOR);
	assign rem = CW'(mag_a) - qd;
	assign qm  = (rem >= CW'(DIVISOR)) ? q0 + WIDTH'(1) : q0;

	always_ff @(posedge clk) begin
		if (en_b) begin
			q <= neg_a ? -$signed(qm) : $signed(qm);
		end
	end

endmodule

`default_nettype wire

@@ rtl/scc_lane.sv @@
// ----------------------------------------------------------------------------
// scc_lane
// One stick channel: mapping, moving-average window, output shaping,
// calibration accumulation and bias register.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_lane #(
	parameter int WINDOW_SIZE   = 8,
	parameter int CALIB_SAMPLES = 50
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire scc_pkg::scc_lane_ctl_t       ctl,
	input  wire scc_pkg::scc_trim_t           trim,
	input  wire logic [scc_pkg::SMP_W-1:0]    sample,
	input  wire logic [((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1)-1:0] slot,
	input  wire logic [((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1)-1:0] nslot,
	input  wire scc_pkg::scc_rd_t             rd,
	input  wire logic [scc_pkg::OUT_W-1:0]    target,
	input  wire logic [scc_pkg::CFG_W-1:0]    snap_hw,
	input  wire logic [scc_pkg::CFG_W-1:0]    trim_step,
	output logic [scc_pkg::OUT_W-1:0]         res
);

	localparam int MW = scc_pkg::MAP_W;
	localparam int BW = scc_pkg::BIAS_W;
	localparam int OW = scc_pkg::OUT_W;
	localparam int SW = $clog2(WINDOW_SIZE) + MW;
	localparam int AW = $clog2(CALIB_SAMPLES) + MW;
	localparam int XW = 15;

	function automatic logic signed [BW-1:0] sat_bias(input logic signed [XW-1:0] v);
		if (v > 15'sd1023) begin
			return 11'sd1023;
		end else if (v < -15'sd1023) begin
			return -11'sd1023;
		end
		return v[BW-1:0];
	endfunction

	function automatic logic signed [BW-1:0] trim_one(
		input logic signed [BW-1:0] b,
		input logic                 en,
		input logic                 neg,
		input logic signed [XW-1:0] st
	);
		logic signed [XW-1:0] t;
		t = neg ? XW'(b) - st : XW'(b) + st;
		return en ? sat_bias(t) : b;
	endfunction

	logic signed [BW-1:0]   bias_q;
	logic signed [13:0]     map_wide;
	logic signed [MW-1:0]   mapped;
	logic signed [MW-1:0]   win_mem [WINDOW_SIZE];
	logic signed [MW-1:0]   rdat_q;
	logic signed [MW-1:0]   mapped_q;
	logic                   ok_q;
	logic                   fwd_q;
	logic signed [MW-1:0]   old_v;
	logic signed [SW-1:0]   sum_q;
	logic signed [SW-1:0]   sum_new;
	logic signed [SW-1:0]   sum_s1;
	logic signed [SW-1:0]   filt_full;
	logic signed [MW-1:0]   filt;
	logic [OW-1:0]          clamp_v;
	logic [OW-1:0]          snap_lo;
	logic [OW-1:0]          snap_hi;
	logic signed [AW-1:0]   accum_q;
	logic signed [AW-1:0]   acc_sum;
	logic signed [AW-1:0]   total_q;
	logic signed [AW-1:0]   avg_full;
	logic signed [MW-1:0]   avg;
	logic signed [XW-1:0]   cal_sum;
	logic signed [XW-1:0]   step_x;
	logic signed [BW-1:0]   bias_base;
	logic signed [BW-1:0]   bias_t1;
	logic signed [BW-1:0]   bias_t2;

	// Map raw sample: 2000 - sample/4 - bias
	assign map_wide = 14'sd2000 - $signed({4'b0, sample[scc_pkg::SMP_W-1:2]}) - 14'(bias_q);
	assign mapped   = map_wide[MW-1:0];

	// Window store: write current slot, prefetch the next slot's old sample
	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			win_mem[slot] <= mapped;
			rdat_q        <= win_mem[nslot];
			mapped_q      <= mapped;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ok_q  <= 1'b0;
			fwd_q <= 1'b0;
		end else if (ctl.acc) begin
			ok_q  <= rd.ok;
			fwd_q <= rd.fwd;
		end
	end

	// Unwritten entries read as zero; a one-deep window forwards its last write
	assign old_v   = ok_q ? (fwd_q ? mapped_q : rdat_q) : '0;
	assign sum_new = sum_q - SW'(old_v) + SW'(mapped);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (ctl.acc) begin
			sum_q <= sum_new;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.acc) begin
			sum_s1 <= sum_new;
		end
	end

	// Window average
	scc_cdiv #(
		.DIVISOR (WINDOW_SIZE),
		.WIDTH   (SW)
	) u_wdiv (
		.clk  (clk),
		.en_a (ctl.en2),
		.en_b (ctl.en3),
		.x    (sum_s1),
		.q    (filt_full)
	);

	assign filt = filt_full[MW-1:0];

	// Clamp, then snap to center inside the deadband
	always_comb begin
		if (filt <= 13'sd1000) begin
			clamp_v = scc_pkg::OUT_MIN;
		end else if (filt >= 13'sd2000) begin
			clamp_v = scc_pkg::OUT_MAX;
		end else begin
			clamp_v = filt[OW-1:0];
		end
	end

	assign snap_lo = scc_pkg::OUT_CENTER - OW'(snap_hw);
	assign snap_hi = scc_pkg::OUT_CENTER + OW'(snap_hw);
	assign res     = (clamp_v >= snap_lo && clamp_v <= snap_hi) ? scc_pkg::OUT_CENTER : clamp_v;

	// Calibration accumulation of filtered values
	assign acc_sum = (ctl.clear ? AW'(0) : accum_q) + AW'(filt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (ctl.fire3 && ctl.take) begin
			accum_q <= acc_sum;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire3 && ctl.take && ctl.cmpl) begin
			total_q <= acc_sum;
		end
	end

	scc_cdiv #(
		.DIVISOR (CALIB_SAMPLES),
		.WIDTH   (AW)
	) u_cdiv (
		.clk  (clk),
		.en_a (ctl.cal_a),
		.en_b (ctl.cal_b),
		.x    (total_q),
		.q    (avg_full)
	);

	assign avg = avg_full[MW-1:0];

	// Bias update: calibration offset first, then the two trim steps
	assign cal_sum   = XW'(bias_q) + XW'(avg) - $signed({4'b0, target});
	assign step_x    = $signed({7'b0, trim_step});
	assign bias_base = ctl.use_cal ? sat_bias(cal_sum) : bias_q;
	assign bias_t1   = trim_one(bias_base, trim.en1, trim.neg1, step_x);
	assign bias_t2   = trim_one(bias_t1, trim.en2, trim.neg2, step_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
		end else if (ctl.bias_we) begin
			bias_q <= bias_t2;
		end
	end

endmodule

`default_nettype wire

@@ rtl/scc_ctl.sv @@
// ----------------------------------------------------------------------------
// scc_ctl
// Scan control shared by all lanes: window slot, calibrate hold and sample
// counters, and the calibration finish sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module scc_ctl #(
	parameter int WINDOW_SIZE   = 8,
	parameter int CALIB_SAMPLES = 50
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  acc,
	input  wire logic                  calib_key,
	input  wire scc_pkg::scc_keys_t    keys,
	input  wire logic                  fire_cmpl,
	output scc_pkg::scc_flags_t        flags,
	output logic [((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1)-1:0] slot,
	output logic [((WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1)-1:0] nslot,
	output scc_pkg::scc_rd_t           rd,
	output logic                       busy,
	output scc_pkg::scc_cal_t          cal,
	output scc_pkg::scc_keys_t         held_keys
);

	localparam int SLW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int CCW = $clog2(CALIB_SAMPLES + 1);
	localparam int HW  = scc_pkg::HC_W;

	logic [SLW-1:0] slot_q;
	logic           full_q;
	logic           last;
	logic [HW-1:0]  hc_q;
	logic [HW-1:0]  hc_inc;
	logic [CCW-1:0] cc_q;
	logic [CCW-1:0] cc_inc;
	logic           busy_q;
	logic           cal_a_q;
	logic           cal_b_q;
	logic           cal_c_q;

	// Window slot and fill flag
	assign last  = (slot_q == SLW'(WINDOW_SIZE - 1));
	assign nslot = last ? '0 : slot_q + SLW'(1);
	assign slot  = slot_q;
	assign rd.ok  = full_q || (nslot <= slot_q);
	assign rd.fwd = (nslot == slot_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
			full_q <= 1'b0;
		end else if (acc) begin
			slot_q <= nslot;
			if (last) begin
				full_q <= 1'b1;
			end
		end
	end

	// Calibration role of the scan being accepted
	assign hc_inc      = (hc_q < scc_pkg::HOLD_SCANS) ? hc_q + HW'(1) : hc_q;
	assign cc_inc      = cc_q + CCW'(1);
	assign flags.take  = calib_key && (hc_inc >= scc_pkg::HOLD_SCANS);
	assign flags.clear = flags.take && (cc_q == '0);
	assign flags.cmpl  = flags.take && (cc_inc >= CCW'(CALIB_SAMPLES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q <= '0;
			cc_q <= '0;
		end else if (acc && calib_key) begin
			hc_q <= flags.cmpl ? '0 : hc_inc;
			if (flags.take) begin
				cc_q <= flags.cmpl ? '0 : cc_inc;
			end
		end
	end

	// Finish sequence: average divide (two steps), then bias write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cal_a_q <= 1'b0;
			cal_b_q <= 1'b0;
			cal_c_q <= 1'b0;
		end else begin
			cal_a_q <= fire_cmpl;
			cal_b_q <= cal_a_q;
			cal_c_q <= cal_b_q;
			if (acc && flags.cmpl) begin
				busy_q <= 1'b1;
			end else if (cal_c_q) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Trim keys of the completing scan apply after the calibration offset
	always_ff @(posedge clk) begin
		if (acc && flags.cmpl) begin
			held_keys <= keys;
		end
	end

	assign busy  = busy_q;
	assign cal.a = cal_a_q;
	assign cal.b = cal_b_q;
	assign cal.c = cal_c_q;

endmodule

`default_nettype wire

@@ rtl/stick_channel_conditioner.sv @@
// ----------------------------------------------------------------------------
// stick_channel_conditioner
// Takes scan transactions (four 12-bit stick samples and key flags) and
// returns for each one transaction of four conditioned channels in
// 1000..2000 plus a calibration-done flag. Four identical lanes process the
// channels side by side; the result register merges them. A result passes
// stages s1, s2, s3 and the result register; a new scan is taken every
// cycle unless the output stalls: the window sum and bias update close
// within the accept cycle. A scan that completes calibration holds in_ready
// low until its new bias has gone through a divide by CALIB_SAMPLES and
// been written. Interrupted calibration resumes where it stopped. Registers
// (APB, byte address 4*i): 0 throttle snap half width, 1 axis snap half
// width, 2 trim step. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module stick_channel_conditioner #(
	parameter int WINDOW_SIZE   = 8,
	parameter int CALIB_SAMPLES = 50
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration port
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [scc_pkg::APB_AW-1:0]    paddr,
	input  wire logic [scc_pkg::APB_DW-1:0]    pwdata,
	output logic [scc_pkg::APB_DW-1:0]         prdata,
	output logic                               pready,
	// Scan input
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire scc_pkg::scc_in_t              in_data,
	// Result output
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output scc_pkg::scc_out_t                  out_data
);

	localparam int SLW = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
	localparam int NCH = scc_pkg::NCH;
	localparam int OW  = scc_pkg::OUT_W;
	localparam int CW  = scc_pkg::CFG_W;

	logic [CW-1:0]          thr_hw_q;
	logic [CW-1:0]          axis_hw_q;
	logic [CW-1:0]          step_q;
	logic [1:0]             reg_idx;
	logic                   cfg_wr;

	logic                   acc;
	logic                   busy;
	logic                   vld_s1;
	logic                   vld_s2;
	logic                   vld_s3;
	scc_pkg::scc_flags_t    fl_s1;
	scc_pkg::scc_flags_t    fl_s2;
	scc_pkg::scc_flags_t    fl_s3;
	logic                   en2;
	logic                   en3;
	logic                   fire3;
	logic                   out_valid_q;
	scc_pkg::scc_out_t      out_q;

	scc_pkg::scc_flags_t    flags_now;
	scc_pkg::scc_rd_t       rd;
	scc_pkg::scc_cal_t      cal;
	scc_pkg::scc_keys_t     keys;
	scc_pkg::scc_keys_t     held_keys;
	scc_pkg::scc_keys_t     tkeys;
	logic [SLW-1:0]         slot;
	logic [SLW-1:0]         nslot;
	scc_pkg::scc_lane_ctl_t lane_ctl;
	scc_pkg::scc_trim_t     lane_trim [NCH];
	logic [scc_pkg::SMP_W-1:0] lane_smp [NCH];
	logic [OW-1:0]          lane_res [NCH];

	// Configuration registers
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_hw_q  <= scc_pkg::THR_SNAP_RST;
			axis_hw_q <= scc_pkg::AXIS_SNAP_RST;
			step_q    <= scc_pkg::TRIM_STEP_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				scc_pkg::REG_THR_SNAP:  thr_hw_q  <= pwdata[CW-1:0];
				scc_pkg::REG_AXIS_SNAP: axis_hw_q <= pwdata[CW-1:0];
				scc_pkg::REG_TRIM_STEP: step_q    <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			scc_pkg::REG_THR_SNAP:  prdata = scc_pkg::APB_DW'(thr_hw_q);
			scc_pkg::REG_AXIS_SNAP: prdata = scc_pkg::APB_DW'(axis_hw_q);
			scc_pkg::REG_TRIM_STEP: prdata = scc_pkg::APB_DW'(step_q);
			default:                prdata = '0;
		endcase
	end

	// Pipeline handshake: each stage moves when the next one frees up
	assign fire3    = vld_s3 && (!out_valid_q || out_ready);
	assign en3      = vld_s2 && (!vld_s3 || fire3);
	assign en2      = vld_s1 && (!vld_s2 || en3);
	assign in_ready = (!vld_s1 || en2) && !busy;
	assign acc      = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (acc) begin
				vld_s1 <= 1'b1;
			end else if (en2) begin
				vld_s1 <= 1'b0;
			end
			if (en2) begin
				vld_s2 <= 1'b1;
			end else if (en3) begin
				vld_s2 <= 1'b0;
			end
			if (en3) begin
				vld_s3 <= 1'b1;
			end else if (fire3) begin
				vld_s3 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fl_s1 <= flags_now;
		end
		if (en2) begin
			fl_s2 <= fl_s1;
		end
		if (en3) begin
			fl_s3 <= fl_s2;
		end
	end

	// Shared scan control
	assign keys.up    = in_data.trim_up;
	assign keys.down  = in_data.trim_down;
	assign keys.left  = in_data.trim_left;
	assign keys.right = in_data.trim_right;

	scc_ctl #(
		.WINDOW_SIZE   (WINDOW_SIZE),
		.CALIB_SAMPLES (CALIB_SAMPLES)
	) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.calib_key (in_data.calib_key),
		.keys      (keys),
		.fire_cmpl (fire3 && fl_s3.cmpl),
		.flags     (flags_now),
		.slot      (slot),
		.nslot     (nslot),
		.rd        (rd),
		.busy      (busy),
		.cal       (cal),
		.held_keys (held_keys)
	);

	// Lane controls
	always_comb begin
		lane_ctl.acc     = acc;
		lane_ctl.en2     = en2;
		lane_ctl.en3     = en3;
		lane_ctl.fire3   = fire3;
		lane_ctl.take    = fl_s3.take;
		lane_ctl.clear   = fl_s3.clear;
		lane_ctl.cmpl    = fl_s3.cmpl;
		lane_ctl.cal_a   = cal.a;
		lane_ctl.cal_b   = cal.b;
		lane_ctl.bias_we = (acc && !flags_now.cmpl) || cal.c;
		lane_ctl.use_cal = cal.c;
	end

	// Trim: pitch up then down, roll left then right
	assign tkeys = cal.c ? held_keys : keys;

	always_comb begin
		lane_trim[scc_pkg::CH_THR]        = '0;
		lane_trim[scc_pkg::CH_YAW]        = '0;
		lane_trim[scc_pkg::CH_PITCH].en1  = tkeys.up;
		lane_trim[scc_pkg::CH_PITCH].neg1 = 1'b1;
		lane_trim[scc_pkg::CH_PITCH].en2  = tkeys.down;
		lane_trim[scc_pkg::CH_PITCH].neg2 = 1'b0;
		lane_trim[scc_pkg::CH_ROLL].en1   = tkeys.left;
		lane_trim[scc_pkg::CH_ROLL].neg1  = 1'b0;
		lane_trim[scc_pkg::CH_ROLL].en2   = tkeys.right;
		lane_trim[scc_pkg::CH_ROLL].neg2  = 1'b1;
	end

	assign lane_smp[scc_pkg::CH_THR]   = in_data.adc_throttle;
	assign lane_smp[scc_pkg::CH_YAW]   = in_data.adc_yaw;
	assign lane_smp[scc_pkg::CH_PITCH] = in_data.adc_pitch;
	assign lane_smp[scc_pkg::CH_ROLL]  = in_data.adc_roll;

	// Channel lanes
	for (genvar c = 0; c < NCH; c++) begin : g_lane
		scc_lane #(
			.WINDOW_SIZE   (WINDOW_SIZE),
			.CALIB_SAMPLES (CALIB_SAMPLES)
		) u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (lane_ctl),
			.trim      (lane_trim[c]),
			.sample    (lane_smp[c]),
			.slot      (slot),
			.nslot     (nslot),
			.rd        (rd),
			.target    ((c == scc_pkg::CH_THR) ? scc_pkg::THR_TARGET : scc_pkg::AXIS_TARGET),
			.snap_hw   ((c == scc_pkg::CH_THR) ? thr_hw_q : axis_hw_q),
			.trim_step (step_q),
			.res       (lane_res[c])
		);
	end

	// Result register merges the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire3) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire3) begin
			out_q.throttle_out <= lane_res[scc_pkg::CH_THR];
			out_q.yaw_out      <= lane_res[scc_pkg::CH_YAW];
			out_q.pitch_out    <= lane_res[scc_pkg::CH_PITCH];
			out_q.roll_out     <= lane_res[scc_pkg::CH_ROLL];
			out_q.calib_done   <= fl_s3.cmpl;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stick channel conditioner. Scan transactions go
// in over valid/ready. Each accepted scan runs through a behavioral copy of
// the mapping, window filter, calibration, deadband and trim logic, and each
// returned transaction is checked field by field. Registers are set over APB
// between phases, and the traffic runs under four input/output idling mixes.
// ----------------------------------------------------------------------------
module testbench;

	localparam int WINDOW_SIZE   = 8;
	localparam int CALIB_SAMPLES = 50;
	localparam int HOLD_LIMIT    = 20;
	localparam int BIAS_LIMIT    = 1023;
	localparam int MAP_TOP       = 2000;
	localparam int NCH           = scc_pkg::NCH;
	localparam int OUT_LO        = int'(scc_pkg::OUT_MIN);
	localparam int OUT_HI        = int'(scc_pkg::OUT_MAX);
	localparam int CENTER        = int'(scc_pkg::OUT_CENTER);
	localparam int THR_TGT       = int'(scc_pkg::THR_TARGET);
	localparam int AXIS_TGT      = int'(scc_pkg::AXIS_TARGET);
	localparam int GAP_CAP       = 20;

	// Trim key patterns
	localparam scc_pkg::scc_keys_t NO_TRIM     = 4'b0000;
	localparam scc_pkg::scc_keys_t PRESS_UP    = 4'b1000;
	localparam scc_pkg::scc_keys_t PRESS_DOWN  = 4'b0100;
	localparam scc_pkg::scc_keys_t PRESS_LEFT  = 4'b0010;
	localparam scc_pkg::scc_keys_t PRESS_RIGHT = 4'b0001;

	logic                       clk       = 1'b0;
	logic                       arst_n    = 1'b0;
	logic                       psel      = 1'b0;
	logic                       penable   = 1'b0;
	logic                       pwrite    = 1'b0;
	logic [scc_pkg::APB_AW-1:0] paddr     = '0;
	logic [scc_pkg::APB_DW-1:0] pwdata    = '0;
	logic [scc_pkg::APB_DW-1:0] prdata;
	logic                       pready;
	logic                       in_valid  = 1'b0;
	logic                       in_ready;
	scc_pkg::scc_in_t           in_data   = '0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	scc_pkg::scc_out_t          out_data;

	stick_channel_conditioner #(
		.WINDOW_SIZE  (WINDOW_SIZE),
		.CALIB_SAMPLES(CALIB_SAMPLES)
	) dut (.*);

	always #5 clk = ~clk;

	// Conditioner state as the bench sees it
	int win_hist [WINDOW_SIZE][NCH];
	int win_sum [NCH];
	int win_pos;
	int bias [NCH];
	int hold_cnt;
	int cal_sum [NCH];
	int cal_cnt;
	int snap_thr;
	int snap_axis;
	int trim_amt;

	scc_pkg::scc_out_t pending_outputs [$];
	scc_pkg::scc_out_t next_expected;

	int send_idle_pct;
	int recv_stall_pct;
	int mismatch_count;
	int scans_sent;
	int results_seen;
	int calibrations_seen;
	int reg_writes;

	function automatic int sat_bias(int v);
		if (v > BIAS_LIMIT) return BIAS_LIMIT;
		if (v < -BIAS_LIMIT) return -BIAS_LIMIT;
		return v;
	endfunction

	// Expected result of one scan; advances the bench copy of the state
	function automatic scc_pkg::scc_out_t condition_scan(scc_pkg::scc_in_t s);
		int raw [NCH];
		int filt [NCH];
		int res [NCH];
		int mapped;
		int v;
		int hw;
		scc_pkg::scc_out_t o;
		raw[scc_pkg::CH_THR]   = int'(s.adc_throttle);
		raw[scc_pkg::CH_YAW]   = int'(s.adc_yaw);
		raw[scc_pkg::CH_PITCH] = int'(s.adc_pitch);
		raw[scc_pkg::CH_ROLL]  = int'(s.adc_roll);
		o = '0;

		// map and push into the moving-average window
		for (int c = 0; c < NCH; c++) begin
			mapped = MAP_TOP - raw[c] / 4 - bias[c];
			win_sum[c] = win_sum[c] - win_hist[win_pos][c] + mapped;
			win_hist[win_pos][c] = mapped;
			filt[c] = win_sum[c] / WINDOW_SIZE;
		end
		win_pos = (win_pos + 1) % WINDOW_SIZE;

		// calibration: hold-off, sampling, bias correction
		if (s.calib_key) begin
			if (hold_cnt < HOLD_LIMIT) hold_cnt++;
			if (hold_cnt >= HOLD_LIMIT) begin
				if (cal_cnt == 0) begin
					for (int c = 0; c < NCH; c++) cal_sum[c] = 0;
				end
				for (int c = 0; c < NCH; c++) cal_sum[c] += filt[c];
				cal_cnt++;
				if (cal_cnt >= CALIB_SAMPLES) begin
					for (int c = 0; c < NCH; c++) begin
						bias[c] = sat_bias(bias[c] + cal_sum[c] / cal_cnt -
							((c == scc_pkg::CH_THR) ? THR_TGT : AXIS_TGT));
					end
					hold_cnt = 0;
					cal_cnt = 0;
					o.calib_done = 1'b1;
				end
			end
		end

		// clamp and deadband snap
		for (int c = 0; c < NCH; c++) begin
			v = filt[c];
			if (v <= OUT_LO) v = OUT_LO;
			else if (v >= OUT_HI) v = OUT_HI;
			hw = (c == scc_pkg::CH_THR) ? snap_thr : snap_axis;
			if (v >= CENTER - hw && v <= CENTER + hw) v = CENTER;
			res[c] = v;
		end

		// trim keys, in fixed order, saturating after each
		if (s.trim_up)
			bias[scc_pkg::CH_PITCH] = sat_bias(bias[scc_pkg::CH_PITCH] - trim_amt);
		if (s.trim_down)
			bias[scc_pkg::CH_PITCH] = sat_bias(bias[scc_pkg::CH_PITCH] + trim_amt);
		if (s.trim_left)
			bias[scc_pkg::CH_ROLL] = sat_bias(bias[scc_pkg::CH_ROLL] + trim_amt);
		if (s.trim_right)
			bias[scc_pkg::CH_ROLL] = sat_bias(bias[scc_pkg::CH_ROLL] - trim_amt);

		o.throttle_out = scc_pkg::OUT_W'(res[scc_pkg::CH_THR]);
		o.yaw_out      = scc_pkg::OUT_W'(res[scc_pkg::CH_YAW]);
		o.pitch_out    = scc_pkg::OUT_W'(res[scc_pkg::CH_PITCH]);
		o.roll_out     = scc_pkg::OUT_W'(res[scc_pkg::CH_ROLL]);
		return o;
	endfunction

	task automatic clear_state();
		for (int i = 0; i < WINDOW_SIZE; i++) begin
			for (int c = 0; c < NCH; c++) win_hist[i][c] = 0;
		end
		for (int c = 0; c < NCH; c++) begin
			win_sum[c] = 0;
			bias[c] = 0;
			cal_sum[c] = 0;
		end
		win_pos = 0;
		hold_cnt = 0;
		cal_cnt = 0;
		snap_thr = int'(scc_pkg::THR_SNAP_RST);
		snap_axis = int'(scc_pkg::AXIS_SNAP_RST);
		trim_amt = int'(scc_pkg::TRIM_STEP_RST);
	endtask

	task automatic report_mismatch(string msg);
		$display("MISMATCH at result %0d: %s", results_seen, msg);
		mismatch_count++;
	endtask

	task automatic check_field(string name, logic [scc_pkg::OUT_W-1:0] got,
			logic [scc_pkg::OUT_W-1:0] exp);
		if (got !== exp) report_mismatch($sformatf("%s is %0d, expected %0d", name, got, exp));
	endtask

	// Result checker and receiver stalls
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("result transaction with none outstanding");
			end else begin
				next_expected = pending_outputs.pop_front();
				check_field("throttle_out", out_data.throttle_out, next_expected.throttle_out);
				check_field("yaw_out", out_data.yaw_out, next_expected.yaw_out);
				check_field("pitch_out", out_data.pitch_out, next_expected.pitch_out);
				check_field("roll_out", out_data.roll_out, next_expected.roll_out);
				check_field("calib_done", scc_pkg::OUT_W'(out_data.calib_done),
					scc_pkg::OUT_W'(next_expected.calib_done));
				if (next_expected.calib_done) calibrations_seen++;
			end
			results_seen++;
		end
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// APB write: setup, access, then idle
	task automatic write_reg(logic [1:0] idx, logic [scc_pkg::CFG_W-1:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= scc_pkg::APB_DW'(val);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		case (idx)
			scc_pkg::REG_THR_SNAP:  snap_thr = int'(val);
			scc_pkg::REG_AXIS_SNAP: snap_axis = int'(val);
			scc_pkg::REG_TRIM_STEP: trim_amt = int'(val);
			default: ;
		endcase
		reg_writes++;
	endtask

	task automatic check_reg(logic [1:0] idx, logic [scc_pkg::CFG_W-1:0] want);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[scc_pkg::CFG_W-1:0] !== want)
			report_mismatch($sformatf("register %0d reads %0d, expected %0d",
				idx, prdata[scc_pkg::CFG_W-1:0], want));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(logic [scc_pkg::CFG_W-1:0] thr, logic [scc_pkg::CFG_W-1:0] axis,
			logic [scc_pkg::CFG_W-1:0] step);
		write_reg(scc_pkg::REG_THR_SNAP, thr);
		write_reg(scc_pkg::REG_AXIS_SNAP, axis);
		write_reg(scc_pkg::REG_TRIM_STEP, step);
	endtask

	task automatic set_idling(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// One scan transaction, with a random idle gap ahead of it
	task automatic send_scan(scc_pkg::scc_in_t item);
		int gap;
		gap = 0;
		while (gap < GAP_CAP && $urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (!in_ready);
		pending_outputs.push_back(condition_scan(item));
		scans_sent++;
	endtask

	// Hold the input off until every outstanding result is back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
	endtask

	function automatic scc_pkg::scc_in_t build_scan(logic [scc_pkg::SMP_W-1:0] thr,
			logic [scc_pkg::SMP_W-1:0] yaw, logic [scc_pkg::SMP_W-1:0] pitch,
			logic [scc_pkg::SMP_W-1:0] roll, logic key, scc_pkg::scc_keys_t trims);
		scc_pkg::scc_in_t s;
		s.adc_throttle = thr;
		s.adc_yaw      = yaw;
		s.adc_pitch    = pitch;
		s.adc_roll     = roll;
		s.calib_key    = key;
		s.trim_up      = trims.up;
		s.trim_down    = trims.down;
		s.trim_left    = trims.left;
		s.trim_right   = trims.right;
		return s;
	endfunction

	// Mix of full range, near-center (for the deadband) and rail samples
	function automatic logic [scc_pkg::SMP_W-1:0] pick_sample();
		case ($urandom_range(3))
			0: return scc_pkg::SMP_W'($urandom_range(2300, 1700));
			1: return ($urandom_range(1) == 0) ? 12'd0 : 12'd4095;
			default: return scc_pkg::SMP_W'($urandom_range(4095));
		endcase
	endfunction

	function automatic scc_pkg::scc_in_t make_scan(logic key, int trim_pct);
		scc_pkg::scc_keys_t k;
		k.up    = ($urandom_range(99) < trim_pct);
		k.down  = ($urandom_range(99) < trim_pct);
		k.left  = ($urandom_range(99) < trim_pct);
		k.right = ($urandom_range(99) < trim_pct);
		return build_scan(pick_sample(), pick_sample(), pick_sample(), pick_sample(), key, k);
	endfunction

	// Reset values, then write and read back every register
	task automatic test_registers();
		check_reg(scc_pkg::REG_THR_SNAP, scc_pkg::THR_SNAP_RST);
		check_reg(scc_pkg::REG_AXIS_SNAP, scc_pkg::AXIS_SNAP_RST);
		check_reg(scc_pkg::REG_TRIM_STEP, scc_pkg::TRIM_STEP_RST);
		configure(8'd0, 8'd255, 8'd1);
		check_reg(scc_pkg::REG_THR_SNAP, 8'd0);
		check_reg(scc_pkg::REG_AXIS_SNAP, 8'd255);
		check_reg(scc_pkg::REG_TRIM_STEP, 8'd1);
		configure(scc_pkg::THR_SNAP_RST, scc_pkg::AXIS_SNAP_RST, scc_pkg::TRIM_STEP_RST);
	endtask

	// Sample extremes, every trim key, and bias saturation both ways
	task automatic test_extremes_and_trim();
		set_idling(0, 0);
		drain_results();
		configure(scc_pkg::THR_SNAP_RST, scc_pkg::AXIS_SNAP_RST, 8'd255);
		send_scan(build_scan(12'd0, 12'd0, 12'd0, 12'd0, 1'b0, NO_TRIM));
		send_scan(build_scan(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b1,
			PRESS_UP | PRESS_DOWN | PRESS_LEFT | PRESS_RIGHT));
		send_scan(build_scan(12'hAAA, 12'h555, 12'hAAA, 12'h555, 1'b0, NO_TRIM));
		send_scan(build_scan(12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b0, PRESS_UP));
		send_scan(build_scan(12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b0, PRESS_DOWN));
		send_scan(build_scan(12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b0, PRESS_LEFT));
		send_scan(build_scan(12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b0, PRESS_RIGHT));
		// opposite keys together cancel away from the rails
		send_scan(build_scan(12'd1000, 12'd3000, 12'd1000, 12'd3000, 1'b0,
			PRESS_UP | PRESS_DOWN));
		send_scan(build_scan(12'd3000, 12'd1000, 12'd3000, 12'd1000, 1'b0,
			PRESS_LEFT | PRESS_RIGHT));
		// pitch bias runs into the negative rail, roll into the positive one
		repeat (5) send_scan(build_scan(12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b0,
			PRESS_UP | PRESS_LEFT));
		// at the rail, opposite keys no longer cancel
		send_scan(build_scan(12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b0,
			PRESS_UP | PRESS_DOWN));
		// full-scale roll with saturated bias drives the window sum negative
		repeat (8) send_scan(build_scan(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0,
			NO_TRIM));
		drain_results();
	endtask

	// Full calibration, one interrupted and resumed, one with trims applied
	task automatic test_calibration();
		set_idling(27, 27);
		configure(scc_pkg::THR_SNAP_RST, scc_pkg::AXIS_SNAP_RST, scc_pkg::TRIM_STEP_RST);
		repeat (75) send_scan(make_scan(1'b1, 0));
		repeat (35) send_scan(make_scan(1'b1, 0));
		repeat (12) send_scan(make_scan(1'b0, 0));
		repeat (40) send_scan(make_scan(1'b1, 0));
		repeat (72) send_scan(make_scan(1'b1, 40));
		drain_results();
	endtask

	// Runs of held and released calibrate key with random content
	task automatic random_phase(int send_pct, int recv_pct, logic [scc_pkg::CFG_W-1:0] thr,
			logic [scc_pkg::CFG_W-1:0] axis, logic [scc_pkg::CFG_W-1:0] step, int count);
		int sent;
		int len;
		logic key;
		drain_results();
		configure(thr, axis, step);
		set_idling(send_pct, recv_pct);
		sent = 0;
		while (sent < count) begin
			key = ($urandom_range(99) < 75);
			len = key ? int'($urandom_range(80, 5)) : int'($urandom_range(15, 1));
			if (len > count - sent) len = count - sent;
			repeat (len) send_scan(make_scan(key, 8));
			sent += len;
		end
	endtask

	task automatic test_random_traffic();
		random_phase(0, 0, 8'd0, 8'd0, 8'd0, 60);
		random_phase(61, 0, 8'd255, 8'd255, 8'd255, 60);
		random_phase(0, 61, scc_pkg::CFG_W'($urandom_range(255)),
			scc_pkg::CFG_W'($urandom_range(255)), scc_pkg::CFG_W'($urandom_range(40)), 60);
		random_phase(27, 27, scc_pkg::CFG_W'($urandom_range(60)),
			scc_pkg::CFG_W'($urandom_range(30)), scc_pkg::CFG_W'($urandom_range(255)), 60);
		drain_results();
	endtask

	initial begin
		mismatch_count = 0;
		scans_sent = 0;
		results_seen = 0;
		calibrations_seen = 0;
		reg_writes = 0;
		set_idling(0, 0);
		clear_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_registers();
		test_extremes_and_trim();
		test_calibration();
		test_random_traffic();

		repeat (20) @(posedge clk);
		$display("Covered %0d scans, %0d results, %0d calibrations, %0d register writes,",
			scans_sent, results_seen, calibrations_seen, reg_writes);
		$display("under no idling, input gaps, output stalls and both combined.");
		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("Timeout with %0d results outstanding", pending_outputs.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/scc_pkg.sv
rtl/scc_cdiv.sv
rtl/scc_lane.sv
rtl/scc_ctl.sv
rtl/stick_channel_conditioner.sv
dv/testbench.sv
